>>> hw/rtl/tspra_pkg.sv
// Shared types, constants and command/status structures of the PID remap allocator.
`default_nettype none

package tspra_pkg;

  localparam int PID_W       = 13;
  localparam int PID_SPACE   = 8192;
  localparam int ENTRY_W     = 16;
  localparam int DEF_CHANNELS = 4;

  localparam logic [PID_W-1:0] PID_LIMIT  = 13'd8191;
  localparam logic [PID_W-1:0] PID_MAX    = 13'd8191;
  localparam logic [PID_W-1:0] FIRST_FREE = 13'h020;
  localparam logic [PID_W-1:0] SCAN_LAST  = 13'd8190;

  // Entry layout: output PID in the low bits, then the three marks.
  localparam int BIT_INPUT = 13;
  localparam int BIT_SEL   = 14;
  localparam int BIT_NEW   = 15;

  typedef enum logic [2:0] {
    ACT_CLEAR = 3'd0,
    ACT_LOAD  = 3'd1,
    ACT_SET   = 3'd2,
    ACT_GETD  = 3'd3,
    ACT_GETP  = 3'd4,
    ACT_CHECK = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    SW_NONE = 3'd0,
    SW_MCLR = 3'd1,
    SW_CHK  = 3'd2,
    SW_BCLR = 3'd3,
    SW_MARK = 3'd4,
    SW_SCAN = 3'd5
  } sweep_t;

  typedef enum logic [2:0] {
    RES_ZERO    = 3'd0,
    RES_ENTRY   = 3'd1,
    RES_IPID    = 3'd2,
    RES_FREE    = 3'd3,
    RES_USE_OWN = 3'd4,
    RES_USE_CHK = 3'd5
  } res_sel_t;

  typedef struct packed {
    logic     take;
    logic     rd_entry;
    logic     wr_entry;
    logic     sweep_start;
    sweep_t   sweep;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       ch_ok;
    logic       ent_sel;
    logic       ent_match;
    logic       sweep_done;
    logic       found;
    logic       hit;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/tspra_dp.sv
// Datapath: item registers, entry table, free-PID bitmaps, sweep counter and result registers.
`default_nettype none

module tspra_dp #(
  parameter int CHANNELS = tspra_pkg::DEF_CHANNELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [2:0]                  action,
  input  wire logic [1:0]                  channel,
  input  wire logic [tspra_pkg::PID_W-1:0] in_pid,
  input  wire logic [tspra_pkg::PID_W-1:0] out_pid,
  input  wire logic                        selected,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [tspra_pkg::PID_W-1:0]      result_pid,
  output logic                             usable,
  output logic                             none_free,
  input  wire tspra_pkg::cmd_t             cmd,
  output tspra_pkg::sts_t                  sts
);
  import tspra_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = CH_W + PID_W;
  localparam int DEPTH = CHANNELS * PID_SPACE;
  localparam logic [CH_W-1:0] C_MAX = CH_W'(CHANNELS - 1);

  // Memories.
  logic [ENTRY_W-1:0] ent_mem [DEPTH];
  logic               nz_mem  [PID_SPACE];
  logic               sel_mem [PID_SPACE];

  // Item registers.
  logic [2:0]       act_q;
  logic [1:0]       ch_q;
  logic [PID_W-1:0] ipid_q;
  logic [PID_W-1:0] opid_q;
  logic             sel_q;
  logic [PID_W-1:0] target;

  // Sweep control and the pipeline registers behind the memory reads.
  sweep_t           mode_q;
  logic             run;
  logic [PID_W-1:0] cnt_p;
  logic [CH_W-1:0]  cnt_c;
  logic             cnt_last;
  logic             entry_sweep;
  logic             pv;
  logic [PID_W-1:0] pp;
  logic [CH_W-1:0]  pc;
  logic             plast;

  logic [ENTRY_W-1:0] ent_rd;
  logic [ENTRY_W-1:0] ent_upd;
  logic [ENTRY_W-1:0] ent_wd;
  logic [AW-1:0]      own_addr;
  logic [AW-1:0]      cnt_addr;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               ent_we;
  logic               ent_new;

  logic             nz_rd;
  logic             sel_rd;
  logic             in_range;
  logic             own_slot;
  logic             hit_now;
  logic             hit_q;
  logic             found_now;
  logic             mark_v;
  logic             nz_now;
  logic             acc_q;
  logic             acc_nz;
  logic             nz_we;
  logic             sel_we;
  logic             bclr_v;
  logic [PID_W-1:0] sel_wa;

  logic [PID_W-1:0] res_pid_q;
  logic             use_q;
  logic             none_q;

  // Latch the transaction payload.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_q  <= action;
      ch_q   <= channel;
      ipid_q <= in_pid;
      opid_q <= out_pid;
      sel_q  <= selected;
    end
  end

  assign target = (act_q == ACT_CHECK) ? opid_q : ipid_q;

  // Sweep counter: PID-major, channel-minor over the table; PID only for bitmaps.
  assign entry_sweep = (mode_q == SW_MCLR) || (mode_q == SW_CHK) || (mode_q == SW_MARK);

  always_comb begin
    if (entry_sweep) begin
      cnt_last = (cnt_p == PID_MAX) && (cnt_c == C_MAX);
    end else if (mode_q == SW_SCAN) begin
      cnt_last = (cnt_p == SCAN_LAST);
    end else begin
      cnt_last = (cnt_p == PID_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      pv     <= 1'b0;
      mode_q <= SW_NONE;
    end else if (cmd.sweep_start) begin
      run    <= 1'b1;
      pv     <= 1'b0;
      mode_q <= cmd.sweep;
    end else begin
      pv  <= run;
      run <= run && !cnt_last && !found_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      cnt_p <= (cmd.sweep == SW_SCAN) ? FIRST_FREE : '0;
      cnt_c <= '0;
    end else if (run) begin
      if (entry_sweep && (cnt_c != C_MAX)) begin
        cnt_c <= cnt_c + 1'b1;
      end else begin
        cnt_c <= '0;
        cnt_p <= cnt_p + 1'b1;
      end
    end
    pp    <= cnt_p;
    pc    <= cnt_c;
    plast <= cnt_last;
  end

  // Entry table: one read and one write port, registered read.
  assign own_addr = {CH_W'(ch_q), ipid_q};
  assign cnt_addr = {cnt_c, cnt_p};
  assign rd_addr  = cmd.rd_entry ? own_addr : cnt_addr;

  assign ent_new = !ent_rd[BIT_SEL] || (ent_rd[PID_W-1:0] != opid_q);

  always_comb begin
    case (act_q)
      ACT_LOAD: begin
        ent_upd = {ent_rd[BIT_NEW], ent_rd[BIT_SEL] | sel_q, 1'b1, opid_q};
      end
      default: begin
        ent_upd = {ent_rd[BIT_NEW] | ent_new, 1'b1, ent_rd[BIT_INPUT], opid_q};
      end
    endcase
  end

  assign ent_we  = cmd.wr_entry || (run && (mode_q == SW_MCLR));
  assign wr_addr = cmd.wr_entry ? own_addr : cnt_addr;
  assign ent_wd  = cmd.wr_entry ? ent_upd : '0;

  always_ff @(posedge clk) begin
    ent_rd <= ent_mem[rd_addr];
    if (ent_we) begin
      ent_mem[wr_addr] <= ent_wd;
    end
  end

  // Qualifiers on the entry that the pipeline stage holds.
  assign in_range = (pp >= FIRST_FREE) && (pp != PID_LIMIT);
  assign own_slot = (4'(pc) == 4'(ch_q)) && (pp == ipid_q);

  // Usability check: another selected entry already maps to the target.
  assign hit_now = pv && (mode_q == SW_CHK) && ent_rd[BIT_SEL] &&
                   (ent_rd[PID_W-1:0] == target) && in_range && !own_slot;

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      hit_q <= 1'b0;
    end else if (hit_now) begin
      hit_q <= 1'b1;
    end
  end

  // Marking pass: any non-zero entry takes its own PID, a selected one its target.
  assign mark_v = pv && (mode_q == SW_MARK);
  assign nz_now = (ent_rd != '0);
  assign acc_nz = (pc == '0) ? nz_now : (acc_q | nz_now);
  assign nz_we  = mark_v && (pc == C_MAX);
  assign bclr_v = run && (mode_q == SW_BCLR);
  assign sel_we = bclr_v || (mark_v && ent_rd[BIT_SEL] && in_range);
  assign sel_wa = bclr_v ? cnt_p : ent_rd[PID_W-1:0];

  always_ff @(posedge clk) begin
    if (mark_v) begin
      acc_q <= acc_nz;
    end
  end

  always_ff @(posedge clk) begin
    nz_rd  <= nz_mem[cnt_p];
    sel_rd <= sel_mem[cnt_p];
    if (nz_we) begin
      nz_mem[pp] <= acc_nz;
    end
    if (sel_we) begin
      sel_mem[sel_wa] <= !bclr_v;
    end
  end

  // Scan from PID 0x20 for the lowest PID that neither bitmap marks.
  assign found_now = pv && (mode_q == SW_SCAN) && !nz_rd && !sel_rd;

  // Result staging.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ENTRY: begin
          res_pid_q <= ent_rd[PID_W-1:0];
          use_q     <= 1'b0;
          none_q    <= 1'b0;
        end
        RES_IPID: begin
          res_pid_q <= ipid_q;
          use_q     <= 1'b0;
          none_q    <= 1'b0;
        end
        RES_FREE: begin
          res_pid_q <= found_now ? pp : PID_LIMIT;
          use_q     <= 1'b0;
          none_q    <= !found_now;
        end
        RES_USE_OWN: begin
          res_pid_q <= '0;
          use_q     <= 1'b1;
          none_q    <= 1'b0;
        end
        RES_USE_CHK: begin
          res_pid_q <= '0;
          use_q     <= !(hit_q | hit_now);
          none_q    <= 1'b0;
        end
        default: begin
          res_pid_q <= '0;
          use_q     <= 1'b0;
          none_q    <= 1'b0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_pid <= res_pid_q;
      usable     <= use_q;
      none_free  <= none_q;
    end
  end

  // Status to the controller.
  assign sts.act        = act_q;
  assign sts.ch_ok      = (int'(ch_q) < CHANNELS);
  assign sts.ent_sel    = ent_rd[BIT_SEL];
  assign sts.ent_match  = (ent_rd[PID_W-1:0] == target);
  assign sts.sweep_done = pv && plast;
  assign sts.found      = found_now;
  assign sts.hit        = hit_q | hit_now;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> hw/rtl/tspra_ctrl.sv
// Controller state machine: sequences table reads, writes and the sweeps of each action.
`default_nettype none

module tspra_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output tspra_pkg::cmd_t      cmd,
  input  wire tspra_pkg::sts_t sts
);
  import tspra_pkg::*;

  typedef enum logic [10:0] {
    S_RST  = 11'b000_0000_0001,
    S_INIT = 11'b000_0000_0010,
    S_IDLE = 11'b000_0000_0100,
    S_READ = 11'b000_0000_1000,
    S_DEC  = 11'b000_0001_0000,
    S_CLR  = 11'b000_0010_0000,
    S_CHK  = 11'b000_0100_0000,
    S_BCLR = 11'b000_1000_0000,
    S_MARK = 11'b001_0000_0000,
    S_SCAN = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_RST: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep       = SW_MCLR;
        state_next      = S_INIT;
      end
      S_INIT: begin
        if (sts.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_entry = 1'b1;
        state_next   = S_DEC;
      end
      S_DEC: begin
        if (!sts.ch_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = S_FIN;
        end else begin
          case (sts.act)
            ACT_CLEAR: begin
              cmd.sweep_start = 1'b1;
              cmd.sweep       = SW_MCLR;
              state_next      = S_CLR;
            end
            ACT_LOAD, ACT_SET: begin
              cmd.wr_entry = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = S_FIN;
            end
            ACT_GETD: begin
              if (sts.ent_sel) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ENTRY;
                state_next   = S_FIN;
              end else begin
                cmd.sweep_start = 1'b1;
                cmd.sweep       = SW_CHK;
                state_next      = S_CHK;
              end
            end
            ACT_GETP: begin
              cmd.sweep_start = 1'b1;
              if (sts.ent_sel) begin
                cmd.sweep  = SW_BCLR;
                state_next = S_BCLR;
              end else begin
                cmd.sweep  = SW_CHK;
                state_next = S_CHK;
              end
            end
            ACT_CHECK: begin
              if (sts.ent_sel && sts.ent_match) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_USE_OWN;
                state_next   = S_FIN;
              end else begin
                cmd.sweep_start = 1'b1;
                cmd.sweep       = SW_CHK;
                state_next      = S_CHK;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = S_FIN;
            end
          endcase
        end
      end
      S_CLR: begin
        if (sts.sweep_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = S_FIN;
        end
      end
      S_CHK: begin
        if (sts.sweep_done) begin
          if (sts.act == ACT_CHECK) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_USE_CHK;
            state_next   = S_FIN;
          end else if (!sts.hit) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_IPID;
            state_next   = S_FIN;
          end else begin
            cmd.sweep_start = 1'b1;
            cmd.sweep       = SW_BCLR;
            state_next      = S_BCLR;
          end
        end
      end
      S_BCLR: begin
        if (sts.sweep_done) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep       = SW_MARK;
          state_next      = S_MARK;
        end
      end
      S_MARK: begin
        if (sts.sweep_done) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep       = SW_SCAN;
          state_next      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.found || sts.sweep_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FREE;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_RST;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/ts_pid_remap_allocator_core.sv
// Top level of the transport-stream PID remap allocator.
//
// One transaction in gives one result out. The table holds CHANNELS x 8192 entries in a
// single-port-read, single-port-write memory and is swept one entry per clock, so timing
// follows the sweeps: after reset a clearing pass over the table runs before the first
// transaction is taken. Load, set, unknown actions and a selected data-PID lookup run no
// sweep. Clear runs one clearing sweep over the table. A usability check or an unmapped
// lookup adds one checking sweep over the table. A free-PID search adds a bitmap clear, a
// marking pass over the table and a scan from PID 0x20 that stops at the first free PID
// (or at PID 8190). A new transaction is accepted as soon as the previous result has
// been placed in the output register.
`default_nettype none

module ts_pid_remap_allocator_core #(
  parameter int CHANNELS = tspra_pkg::DEF_CHANNELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  action,
  input  wire logic [1:0]                  channel,
  input  wire logic [tspra_pkg::PID_W-1:0] in_pid,
  input  wire logic [tspra_pkg::PID_W-1:0] out_pid,
  input  wire logic                        selected,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tspra_pkg::PID_W-1:0]      result_pid,
  output logic                             usable,
  output logic                             none_free
);
  import tspra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  tspra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Storage and computation.
  tspra_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .channel    (channel),
    .in_pid     (in_pid),
    .out_pid    (out_pid),
    .selected   (selected),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .result_pid (result_pid),
    .usable     (usable),
    .none_free  (none_free),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tspra_checker.sv
// Port-level checker for the PID remap allocator and its bind to the top level.
`default_nettype none

module tspra_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [12:0] result_pid,
  input wire logic        usable,
  input wire logic        none_free
);

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_pid) && $stable(usable)
      && $stable(none_free))
    else $error("output transaction changed while stalled");

  // An exhausted free search always reports the limit PID.
  a_none_pid: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_free |-> result_pid == 13'h1FFF && !usable)
    else $error("none_free without limit PID");

  // A usability answer carries no PID.
  a_use_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && usable |-> result_pid == 13'd0)
    else $error("usable result carries a PID");

  // One transaction at a time: no acceptance in the cycle after one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

endmodule

bind ts_pid_remap_allocator_core tspra_checker u_tspra_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .result_pid (result_pid),
  .usable     (usable),
  .none_free  (none_free)
);

`default_nettype wire
